// ----- sv/dged_pkg.sv -----
// ---------------------------------------------------------------------------
// dged_pkg
// Shared types and codes of the debounced GPIO edge detector.
// ---------------------------------------------------------------------------
package dged_pkg;

   localparam int LEVEL_W = 32;
   localparam int COUNT_W = 6;
   localparam int INDEX_W = 5;
   localparam int FLAG_W  = 2;
   localparam int CSR_W   = 3;

   // Commands.
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_READ   = 1'b1;

   // Edge flag codes.
   localparam logic [FLAG_W-1:0] EDGE_NONE = 2'd0;

   // Register indexes.
   localparam logic [CSR_W-1:0] REG_PINS_IN_USE  = 3'd0;
   localparam logic [CSR_W-1:0] REG_ACTIVE_LEVEL = 3'd1;
   localparam logic [CSR_W-1:0] REG_RISING_EN    = 3'd2;
   localparam logic [CSR_W-1:0] REG_FALLING_EN   = 3'd3;
   localparam logic [CSR_W-1:0] REG_NOTIFY_EN    = 3'd4;

   typedef struct packed {
      logic [COUNT_W-1:0] pins_in_use;
      logic [LEVEL_W-1:0] active_level_mask;
      logic [LEVEL_W-1:0] rising_enable_mask;
      logic [LEVEL_W-1:0] falling_enable_mask;
      logic [LEVEL_W-1:0] notify_enable_mask;
   } cfg_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] stable_levels;
      logic [LEVEL_W-1:0] rising_pins;
      logic [LEVEL_W-1:0] falling_pins;
      logic [LEVEL_W-1:0] notify_pins;
      logic [FLAG_W-1:0]  edge_flag;
      logic               index_error;
   } result_type;

endpackage

// ----- sv/dged_csr.sv -----
// ---------------------------------------------------------------------------
// dged_csr
// Configuration registers, written one at a time through the csr channel.
// ---------------------------------------------------------------------------
module dged_csr
   import dged_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write,
   input  logic [CSR_W-1:0]    csr_index,
   input  logic [LEVEL_W-1:0]  csr_data,
   output cfg_type             cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_PINS_IN_USE:  cfg_in.pins_in_use         = csr_data[COUNT_W-1:0];
            REG_ACTIVE_LEVEL: cfg_in.active_level_mask   = csr_data;
            REG_RISING_EN:    cfg_in.rising_enable_mask  = csr_data;
            REG_FALLING_EN:   cfg_in.falling_enable_mask = csr_data;
            REG_NOTIFY_EN:    cfg_in.notify_enable_mask  = csr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pins_in_use         <= COUNT_W'(LEVEL_W);
         cfg_ff.active_level_mask   <= '1;
         cfg_ff.rising_enable_mask  <= '0;
         cfg_ff.falling_enable_mask <= '0;
         cfg_ff.notify_enable_mask  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- sv/dged_core.sv -----
// ---------------------------------------------------------------------------
// dged_core
// Debounce state, edge flags and the per-item datapath.
// ---------------------------------------------------------------------------
module dged_core
   import dged_pkg::*;
#(
   parameter int PIN_COUNT = 32
)
(
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                fire,
   input  logic                command,
   input  logic [LEVEL_W-1:0]  pin_levels,
   input  logic [INDEX_W-1:0]  pin_index,
   output result_type          result
);

   localparam int IDX_W = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;
   localparam logic [COUNT_W-1:0] PIN_LIMIT = COUNT_W'(PIN_COUNT);

   logic [LEVEL_W-1:0] stable_ff,     stable_in;
   logic [LEVEL_W-1:0] candidate_ff,  candidate_in;
   logic               confirming_ff, confirming_in;
   logic [FLAG_W-1:0]  flags_ff [PIN_COUNT];
   logic [FLAG_W-1:0]  flags_in [PIN_COUNT];

   logic [COUNT_W-1:0] used_count;
   logic [LEVEL_W-1:0] used_mask;
   logic [LEVEL_W-1:0] logical;
   logic [LEVEL_W-1:0] diff;
   logic [LEVEL_W-1:0] rise;
   logic [LEVEL_W-1:0] fall;
   logic               confirm;
   logic               read_err;
   logic [IDX_W-1:0]   read_idx;

   assign used_count = (cfg.pins_in_use > PIN_LIMIT) ? PIN_LIMIT : cfg.pins_in_use;

   always_comb begin
      for (int i = 0; i < LEVEL_W; i++) begin
         used_mask[i] = (COUNT_W'(i) < used_count);
      end
   end

   assign logical  = ~(pin_levels ^ cfg.active_level_mask) & used_mask;
   assign confirm  = (command == CMD_SAMPLE) && confirming_ff && (logical == candidate_ff);
   assign diff     = confirm ? ((logical ^ stable_ff) & used_mask) : '0;
   assign rise     = diff & logical;
   assign fall     = diff & ~logical;
   assign read_err = ({1'b0, pin_index} >= used_count);
   assign read_idx = pin_index[IDX_W-1:0];

   always_comb begin
      stable_in     = stable_ff;
      candidate_in  = candidate_ff;
      confirming_in = confirming_ff;
      for (int p = 0; p < PIN_COUNT; p++) begin
         flags_in[p] = flags_ff[p];
      end
      if (command == CMD_SAMPLE) begin
         if (confirming_ff) begin
            // A mismatching second sample is simply dropped.
            confirming_in = 1'b0;
            if (confirm) begin
               stable_in = logical;
            end
         end else if (logical != (stable_ff & used_mask)) begin
            candidate_in  = logical;
            confirming_in = 1'b1;
         end
         for (int p = 0; p < PIN_COUNT; p++) begin
            if (diff[p]) begin
               flags_in[p] = {fall[p] & cfg.falling_enable_mask[p],
                              rise[p] & cfg.rising_enable_mask[p]};
            end
         end
      end else if (!read_err) begin
         flags_in[read_idx] = EDGE_NONE;
      end
   end

   always_comb begin
      result.stable_levels = stable_in;
      result.rising_pins   = rise;
      result.falling_pins  = fall;
      result.notify_pins   = ((rise & cfg.rising_enable_mask) |
                              (fall & cfg.falling_enable_mask)) & cfg.notify_enable_mask;
      result.index_error   = (command == CMD_READ) && read_err;
      result.edge_flag     = ((command == CMD_READ) && !read_err) ? flags_ff[read_idx]
                                                                  : EDGE_NONE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff     <= '0;
         candidate_ff  <= '0;
         confirming_ff <= 1'b0;
         for (int p = 0; p < PIN_COUNT; p++) begin
            flags_ff[p] <= EDGE_NONE;
         end
      end else if (fire) begin
         stable_ff     <= stable_in;
         candidate_ff  <= candidate_in;
         confirming_ff <= confirming_in;
         for (int p = 0; p < PIN_COUNT; p++) begin
            flags_ff[p] <= flags_in[p];
         end
      end
   end

   // A confirm phase never lasts past the next sample.
   a_confirm_ends: assert property (@(posedge clock) disable iff (reset)
      fire && command == CMD_SAMPLE && confirming_ff |=> !confirming_ff)
      else $error("confirm phase survived a sample");

   // Stable bits only change through a confirmed sample.
   a_stable_only_on_confirm: assert property (@(posedge clock) disable iff (reset)
      !(fire && confirm) |=> $stable(stable_ff))
      else $error("stable vector changed without confirmation");

endmodule

// ----- sv/debounced_gpio_edge_detector.sv -----
// ---------------------------------------------------------------------------
// debounced_gpio_edge_detector
// Multi-pin input port with two-sample debounce and per-pin edge flags.
// ---------------------------------------------------------------------------
//
//   channel  handshake              payload
//   req      req_valid / req_stall  command, pin_levels, pin_index
//   rsp      rsp_valid / rsp_stall  stable_levels, rising/falling/notify_pins,
//                                   edge_flag, index_error
//   csr      csr_valid / csr_ready  csr_index, csr_data
//
// Each beat passes from req to rsp through two registers: the input register,
// then through the debounce logic into the result register.
// A new beat is accepted every cycle while req_stall is low; the state update of one item completes
// in the cycle that moves it into the result register.
// Reset clears the debounce state and all edge flags and loads the register
// defaults; no clearing pass is needed.
// A rsp stall backs up into req_stall only when both registers are full.
// ---------------------------------------------------------------------------
module debounced_gpio_edge_detector
   import dged_pkg::*;
#(
   parameter int PIN_COUNT = 32
)
(
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_command,
   input  logic [LEVEL_W-1:0]  req_pin_levels,
   input  logic [INDEX_W-1:0]  req_pin_index,

   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [LEVEL_W-1:0]  rsp_stable_levels,
   output logic [LEVEL_W-1:0]  rsp_rising_pins,
   output logic [LEVEL_W-1:0]  rsp_falling_pins,
   output logic [LEVEL_W-1:0]  rsp_notify_pins,
   output logic [FLAG_W-1:0]   rsp_edge_flag,
   output logic                rsp_index_error,

   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CSR_W-1:0]    csr_index,
   input  logic [LEVEL_W-1:0]  csr_data
);

   cfg_type            cfg;
   result_type         result;

   logic               s1_valid_ff, s1_valid_in;
   logic               s1_command_ff;
   logic [LEVEL_W-1:0] s1_levels_ff;
   logic [INDEX_W-1:0] s1_index_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_data_ff;

   logic               rsp_free;
   logic               advance;
   logic               req_take;

   assign csr_ready = 1'b1;

   dged_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   dged_core #(.PIN_COUNT(PIN_COUNT)) u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .fire       (advance),
      .command    (s1_command_ff),
      .pin_levels (s1_levels_ff),
      .pin_index  (s1_index_ff),
      .result     (result)
   );

   assign rsp_free     = !rsp_valid_ff || !rsp_stall;
   assign advance      = s1_valid_ff && rsp_free;
   assign req_stall    = s1_valid_ff && !rsp_free;
   assign req_take     = req_valid && !req_stall;
   assign s1_valid_in  = req_take || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_command_ff <= req_command;
         s1_levels_ff  <= req_pin_levels;
         s1_index_ff   <= req_pin_index;
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_stable_levels = rsp_data_ff.stable_levels;
   assign rsp_rising_pins   = rsp_data_ff.rising_pins;
   assign rsp_falling_pins  = rsp_data_ff.falling_pins;
   assign rsp_notify_pins   = rsp_data_ff.notify_pins;
   assign rsp_edge_flag     = rsp_data_ff.edge_flag;
   assign rsp_index_error   = rsp_data_ff.index_error;

   // A pin cannot rise and fall in the same beat.
   a_no_double_edge: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.rising_pins & rsp_data_ff.falling_pins) == '0)
      else $error("pin reported both rising and falling");

   // Notification is only raised for a pin that changed.
   a_notify_subset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
         (rsp_data_ff.notify_pins & ~(rsp_data_ff.rising_pins | rsp_data_ff.falling_pins)) == '0)
      else $error("notify on a pin without an edge");

   // A beat held in the input register stays there until it can move on.
   a_s1_held: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !rsp_free |=> s1_valid_ff)
      else $error("input register lost a beat");

endmodule
